// ----- design/gha_pkg.sv -----
// ---------------------------------------------------------------------------
// gha_pkg
// shared widths, register indexes, fixed-point constants and the
// elaboration-time builder for the exp(-x) lookup table
// ---------------------------------------------------------------------------
package gha_pkg;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_STRIDE      = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INV_TWO_SIGMA_SQ = 1'd1;

   // field widths
   localparam int unsigned STRIDE_W = 5;
   localparam int unsigned INV_W    = 20;
   localparam int unsigned CSR_W    = 20;
   localparam int unsigned COORD_W  = 16;
   localparam int unsigned INDEX_W  = 10;
   localparam int unsigned VALUE_W  = 16;

   // datapath widths
   localparam int unsigned DELTA_W  = 21;   // signed distance, 1/16 px
   localparam int unsigned SQ_W     = 40;   // squared distance, 1/256 px^2
   localparam int unsigned HALF_W   = 20;   // half of the squared distance
   localparam int unsigned PROD_W   = 60;   // squared distance times scale
   localparam int unsigned EXP_W    = 19;   // exponent below the cutoff, Q16
   localparam int unsigned SPAN_SHIFT = 19; // table span of one entry, Q16 * depth

   // reset values
   localparam logic [STRIDE_W-1:0] GRID_STRIDE_RST      = 5'd8;
   localparam logic [INV_W-1:0]    INV_TWO_SIGMA_SQ_RST = 20'd669;

   // grid bound, one cell past the last valid index
   localparam logic [INDEX_W:0] MAX_GRID = 11'd1024;

   // exponent cutoff in Q16, just above ln(100)
   localparam logic [PROD_W-9:0] CUTOFF_Q16 = 52'd301806;

   // 1.0 in Q1.15
   localparam logic [VALUE_W:0] ONE_Q15 = 17'd32768;

   localparam logic [63:0] Q60_ONE = 64'h1000_0000_0000_0000;
   localparam logic [63:0] Q15_ROUND = 64'h0000_1000_0000_0000;

   // (a * b) >> 60, truncated
   function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[123:60];
   endfunction

   // exp(-h) in Q60 from the series up to the h^30 term, h given in Q60
   function automatic logic [63:0] exp_step_q60(input logic [63:0] h);
      logic [63:0] acc;
      logic [63:0] term;
      acc  = Q60_ONE;
      term = Q60_ONE;
      for (int unsigned n = 1; n <= 30; n++) begin
         term = mul_q60(term, h) / 64'(n);
         if (n[0]) begin
            acc = acc - term;
         end else begin
            acc = acc + term;
         end
      end
      return acc;
   endfunction

   // table entry k: ratio^k in Q60, rounded half up to Q1.15
   function automatic logic [VALUE_W-1:0] exp_entry(input logic [63:0] ratio,
                                                    input int unsigned k);
      logic [63:0] v;
      logic [63:0] rounded;
      v = Q60_ONE;
      for (int unsigned j = 0; j < k; j++) begin
         v = mul_q60(v, ratio);
      end
      rounded = (v + Q15_ROUND) >> 45;
      return rounded[VALUE_W-1:0];
   endfunction

endpackage

// ----- design/gaussian_heatmap_accumulate.sv -----
// ---------------------------------------------------------------------------
// gaussian_heatmap_accumulate
// adds one gaussian keypoint contribution to a stream of heatmap cells
// ---------------------------------------------------------------------------
// usage:
//   req channel carries one cell per transaction: keypoint center (1/16 px),
//   cell column and row, and the cell's current Q1.15 value
//   rsp channel returns one transaction per cell: the updated value, whether
//   a contribution was added, and whether the sum was clamped at 1.0
//   csr port writes grid_stride (index 0) and inv_two_sigma_sq (index 1); the user
//   writes them only while no transaction is in flight, not enforced by the block
// stage flow: the edge that accepts a req transaction loads it into stage 1, and
//   it moves through stages 2 to 9; rsp_valid is the stage 9 valid
// throughput: one cell per cycle while rsp is not stalled, set by a
//   nine-stage register pipeline
// reset: synchronous, clears all stage valids and loads the register
//   defaults (stride 8, scale 669); the exp table is constant logic
// stall: a stalled rsp holds its payload; upstream stages keep filling
//   empty slots, and req_stall rises only once every stage is occupied
// ---------------------------------------------------------------------------
module gaussian_heatmap_accumulate #(
   parameter int unsigned EXP_TABLE_DEPTH = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration
   input  logic                                 csr_wr_en,
   input  logic [gha_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [gha_pkg::CSR_W-1:0]            csr_wdata,
   // cell requests
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [gha_pkg::COORD_W-1:0]   req_center_x,
   input  logic signed [gha_pkg::COORD_W-1:0]   req_center_y,
   input  logic [gha_pkg::INDEX_W-1:0]          req_cell_col,
   input  logic [gha_pkg::INDEX_W-1:0]          req_cell_row,
   input  logic [gha_pkg::VALUE_W-1:0]          req_old_value,
   // updated cells
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [gha_pkg::VALUE_W-1:0]          rsp_new_value,
   output logic                                 rsp_applied,
   output logic                                 rsp_saturated
);
   import gha_pkg::*;

   // table index needs to reach entry EXP_TABLE_DEPTH (interpolation partner)
   localparam int unsigned IDX_W = $clog2(EXP_TABLE_DEPTH + 1);
   localparam int unsigned POS_W = EXP_W + IDX_W;
   // one table step is 8/EXP_TABLE_DEPTH in Q60
   localparam logic [63:0] EXP_STEP_H = 64'h8000_0000_0000_0000 / EXP_TABLE_DEPTH;
   localparam logic [63:0] EXP_RATIO  = exp_step_q60(EXP_STEP_H);
   localparam int unsigned STAGES = 9;

   // ------------------------------------------------------------------
   // exp(-8k/depth) table, Q1.15, built at elaboration
   // ------------------------------------------------------------------
   logic [VALUE_W-1:0] exp_rom [EXP_TABLE_DEPTH+1];

   for (genvar k = 0; k <= EXP_TABLE_DEPTH; k++) begin : g_exp_rom
      localparam logic [VALUE_W-1:0] ENTRY = exp_entry(EXP_RATIO, k);
      assign exp_rom[k] = ENTRY;
   end

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [STRIDE_W-1:0] grid_stride_ff;
   logic [INV_W-1:0]    inv_sigma_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_stride_ff <= GRID_STRIDE_RST;
         inv_sigma_ff   <= INV_TWO_SIGMA_SQ_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_GRID_STRIDE:      grid_stride_ff <= csr_wdata[STRIDE_W-1:0];
            CSR_INV_TWO_SIGMA_SQ: inv_sigma_ff   <= csr_wdata[INV_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // pipeline flow control: a stage loads when it is empty or when the
   // stage after it loads, so bubbles collapse under a stalled output
   // ------------------------------------------------------------------
   logic [STAGES:1] valid_ff;
   logic [STAGES:1] load;

   always_comb begin
      load[STAGES] = !valid_ff[STAGES] || !rsp_stall;
      for (int s = STAGES - 1; s >= 1; s--) begin
         load[s] = !valid_ff[s] || load[s+1];
      end
   end

   assign req_stall = !load[1];
   assign rsp_valid = valid_ff[STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (load[1]) begin
            valid_ff[1] <= req_valid;
         end
         for (int s = 2; s <= STAGES; s++) begin
            if (load[s]) begin
               valid_ff[s] <= valid_ff[s-1];
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // stage 1: cell position stride*(16*idx + 8) - 8, minus the center
   // ------------------------------------------------------------------
   logic [INDEX_W+3:0]          col_pos;
   logic [INDEX_W+3:0]          row_pos;
   logic [INDEX_W+STRIDE_W+3:0] col_scaled;
   logic [INDEX_W+STRIDE_W+3:0] row_scaled;
   logic signed [DELTA_W-1:0]   s1_dx_in;
   logic signed [DELTA_W-1:0]   s1_dy_in;
   logic                        s1_inside_in;

   assign col_pos    = {req_cell_col, 4'b1000};
   assign row_pos    = {req_cell_row, 4'b1000};
   assign col_scaled = (INDEX_W+STRIDE_W+4)'(grid_stride_ff) * (INDEX_W+STRIDE_W+4)'(col_pos);
   assign row_scaled = (INDEX_W+STRIDE_W+4)'(grid_stride_ff) * (INDEX_W+STRIDE_W+4)'(row_pos);
   assign s1_dx_in = $signed({2'b00, col_scaled}) - DELTA_W'(8)
                     - $signed({{(DELTA_W-COORD_W){req_center_x[COORD_W-1]}}, req_center_x});
   assign s1_dy_in = $signed({2'b00, row_scaled}) - DELTA_W'(8)
                     - $signed({{(DELTA_W-COORD_W){req_center_y[COORD_W-1]}}, req_center_y});
   // cells past the grid are passed through untouched
   assign s1_inside_in = ({1'b0, req_cell_col} < MAX_GRID) && ({1'b0, req_cell_row} < MAX_GRID);

   logic signed [DELTA_W-1:0] s1_dx_ff;
   logic signed [DELTA_W-1:0] s1_dy_ff;
   logic                      s1_inside_ff;
   logic [VALUE_W-1:0]        s1_old_ff;

   always_ff @(posedge clock) begin
      if (load[1]) begin
         s1_dx_ff     <= s1_dx_in;
         s1_dy_ff     <= s1_dy_in;
         s1_inside_ff <= s1_inside_in;
         s1_old_ff    <= req_old_value;
      end
   end

   // ------------------------------------------------------------------
   // stage 2: square each axis
   // ------------------------------------------------------------------
   logic signed [2*DELTA_W-1:0] dx_sq;
   logic signed [2*DELTA_W-1:0] dy_sq;

   assign dx_sq = (2*DELTA_W)'(s1_dx_ff) * (2*DELTA_W)'(s1_dx_ff);
   assign dy_sq = (2*DELTA_W)'(s1_dy_ff) * (2*DELTA_W)'(s1_dy_ff);

   logic [SQ_W-1:0]    s2_dx2_ff;
   logic [SQ_W-1:0]    s2_dy2_ff;
   logic               s2_inside_ff;
   logic [VALUE_W-1:0] s2_old_ff;

   always_ff @(posedge clock) begin
      if (load[2]) begin
         s2_dx2_ff    <= dx_sq[SQ_W-1:0];
         s2_dy2_ff    <= dy_sq[SQ_W-1:0];
         s2_inside_ff <= s1_inside_ff;
         s2_old_ff    <= s1_old_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 3: squared distance
   // ------------------------------------------------------------------
   logic [SQ_W-1:0]    s3_d2_ff;
   logic               s3_inside_ff;
   logic [VALUE_W-1:0] s3_old_ff;

   always_ff @(posedge clock) begin
      if (load[3]) begin
         s3_d2_ff     <= s2_dx2_ff + s2_dy2_ff;
         s3_inside_ff <= s2_inside_ff;
         s3_old_ff    <= s2_old_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 4: scale by 1/(2 sigma^2), split into two 20x20 products
   // ------------------------------------------------------------------
   logic [2*HALF_W-1:0] prod_hi_in;
   logic [2*HALF_W-1:0] prod_lo_in;

   assign prod_hi_in = (2*HALF_W)'(s3_d2_ff[SQ_W-1:HALF_W]) * (2*HALF_W)'(inv_sigma_ff);
   assign prod_lo_in = (2*HALF_W)'(s3_d2_ff[HALF_W-1:0]) * (2*HALF_W)'(inv_sigma_ff);

   logic [2*HALF_W-1:0] s4_prod_hi_ff;
   logic [2*HALF_W-1:0] s4_prod_lo_ff;
   logic                s4_inside_ff;
   logic [VALUE_W-1:0]  s4_old_ff;

   always_ff @(posedge clock) begin
      if (load[4]) begin
         s4_prod_hi_ff <= prod_hi_in;
         s4_prod_lo_ff <= prod_lo_in;
         s4_inside_ff  <= s3_inside_ff;
         s4_old_ff     <= s3_old_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 5: recombine, Q16 exponent and cutoff test
   // ------------------------------------------------------------------
   logic [PROD_W-1:0]   prod_full;
   logic [PROD_W-9:0]   expo_full;
   logic                s5_pass_in;

   assign prod_full  = {s4_prod_hi_ff, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, s4_prod_lo_ff};
   assign expo_full  = prod_full[PROD_W-1:8];
   assign s5_pass_in = !s4_inside_ff || (expo_full > CUTOFF_Q16);

   logic [EXP_W-1:0]   s5_expo_ff;
   logic               s5_pass_ff;
   logic [VALUE_W-1:0] s5_old_ff;

   always_ff @(posedge clock) begin
      if (load[5]) begin
         s5_expo_ff <= expo_full[EXP_W-1:0];
         s5_pass_ff <= s5_pass_in;
         s5_old_ff  <= s4_old_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 6: table position, integer index and fraction
   // below the cutoff the index stays under EXP_TABLE_DEPTH
   // ------------------------------------------------------------------
   logic [POS_W-1:0] table_pos;

   assign table_pos = POS_W'(s5_expo_ff) * POS_W'(EXP_TABLE_DEPTH);

   logic [IDX_W-1:0]      s6_idx_ff;
   logic [SPAN_SHIFT-1:0] s6_frac_ff;
   logic                  s6_pass_ff;
   logic [VALUE_W-1:0]    s6_old_ff;

   always_ff @(posedge clock) begin
      if (load[6]) begin
         s6_idx_ff  <= table_pos[POS_W-1:SPAN_SHIFT];
         s6_frac_ff <= table_pos[SPAN_SHIFT-1:0];
         s6_pass_ff <= s5_pass_ff;
         s6_old_ff  <= s5_old_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 7: read both neighboring table entries
   // ------------------------------------------------------------------
   logic [IDX_W-1:0] idx_next;

   assign idx_next = s6_idx_ff + IDX_W'(1);

   logic [VALUE_W-1:0]    s7_hi_ff;
   logic [VALUE_W-1:0]    s7_lo_ff;
   logic [SPAN_SHIFT-1:0] s7_frac_ff;
   logic                  s7_pass_ff;
   logic [VALUE_W-1:0]    s7_old_ff;

   always_ff @(posedge clock) begin
      if (load[7]) begin
         s7_hi_ff   <= exp_rom[s6_idx_ff];
         s7_lo_ff   <= exp_rom[idx_next];
         s7_frac_ff <= s6_frac_ff;
         s7_pass_ff <= s6_pass_ff;
         s7_old_ff  <= s6_old_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 8: linear interpolation, hi - floor((hi - lo) * frac)
   // ------------------------------------------------------------------
   logic [VALUE_W-1:0]            step_diff;
   logic [VALUE_W+SPAN_SHIFT-1:0] step_scaled;
   logic [VALUE_W-1:0]            s8_contrib_in;

   assign step_diff     = s7_hi_ff - s7_lo_ff;
   assign step_scaled   = (VALUE_W+SPAN_SHIFT)'(step_diff) * (VALUE_W+SPAN_SHIFT)'(s7_frac_ff);
   assign s8_contrib_in = s7_hi_ff - step_scaled[VALUE_W+SPAN_SHIFT-1:SPAN_SHIFT];

   logic [VALUE_W-1:0] s8_contrib_ff;
   logic               s8_pass_ff;
   logic [VALUE_W-1:0] s8_old_ff;

   always_ff @(posedge clock) begin
      if (load[8]) begin
         s8_contrib_ff <= s8_contrib_in;
         s8_pass_ff    <= s7_pass_ff;
         s8_old_ff     <= s7_old_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 9: accumulate and clamp at 1.0, output register
   // a sum of exactly 1.0 is not counted as clamped
   // ------------------------------------------------------------------
   logic [VALUE_W:0]   acc_sum;
   logic [VALUE_W-1:0] new_value_in;
   logic               applied_in;
   logic               saturated_in;

   assign acc_sum = {1'b0, s8_old_ff} + {1'b0, s8_contrib_ff};

   always_comb begin
      new_value_in = s8_old_ff;
      applied_in   = 1'b0;
      saturated_in = 1'b0;
      priority if (s8_pass_ff) begin
         new_value_in = s8_old_ff;
      end else if (acc_sum > ONE_Q15) begin
         new_value_in = ONE_Q15[VALUE_W-1:0];
         applied_in   = 1'b1;
         saturated_in = 1'b1;
      end else begin
         new_value_in = acc_sum[VALUE_W-1:0];
         applied_in   = 1'b1;
      end
   end

   logic [VALUE_W-1:0] rsp_new_value_ff;
   logic               rsp_applied_ff;
   logic               rsp_saturated_ff;

   always_ff @(posedge clock) begin
      if (load[9]) begin
         rsp_new_value_ff <= new_value_in;
         rsp_applied_ff   <= applied_in;
         rsp_saturated_ff <= saturated_in;
      end
   end

   assign rsp_new_value = rsp_new_value_ff;
   assign rsp_applied   = rsp_applied_ff;
   assign rsp_saturated = rsp_saturated_ff;

endmodule
